// File: hdl/ibrl_pkg.sv
// ----------------------------------------------------------------------------
// ibrl_pkg
// Shared types and constants of the implicit B-tree range lookup unit:
// command codes, item field layout and the controller/datapath interface.
// ----------------------------------------------------------------------------
package ibrl_pkg;

    // Command codes carried in the input tuser
    localparam int CMD_W = 2;
    localparam logic [CMD_W-1:0] CMD_KEY_WR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ENT_WR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

    // Input item fields
    localparam int LEVEL_W  = 2;
    localparam int SLOT_W   = 10;
    localparam int KEY_W    = 32;
    localparam int TID_W    = 16;
    localparam int SECTOR_W = 32;

    localparam int LEVEL_LSB   = 0;
    localparam int SLOT_LSB    = LEVEL_LSB + LEVEL_W;
    localparam int KEY_LSB     = SLOT_LSB + SLOT_W;
    localparam int PRES_LSB    = KEY_LSB + KEY_W;
    localparam int TID_LSB     = PRES_LSB + 1;
    localparam int SECTOR_LSB  = TID_LSB + TID_W;
    localparam int IN_FIELDS_W = SECTOR_LSB + SECTOR_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

    // Result item fields
    localparam int LEAF_SLOT_W  = 10;
    localparam int LEAF_LSB     = 0;
    localparam int FTID_LSB     = LEAF_LSB + LEAF_SLOT_W;
    localparam int IOERR_LSB    = FTID_LSB + TID_W;
    localparam int OUT_FIELDS_W = IOERR_LSB + 1;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [LEAF_SLOT_W-1:0] LEAF_SLOT_MAX = '1;

    // Tree depth register
    localparam int DEPTH_W = 3;

    // Controller to datapath commands
    typedef struct packed {
        logic clr;       // clear one row of each store
        logic cap;       // capture the input item
        logic kdiv;      // split key slot into node row and lane
        logic kwr;       // write one key
        logic ewr;       // write one target entry
        logic node_rd;   // read the node row of the current level
        logic node_cmp;  // search the node and step down
        logic tgt_rd;    // read the target entry of the leaf
        logic load_out;  // load the result register
    } t_ctl_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic             clr_last;
        logic             depth_zero;
        logic             lvl_last;
        logic [CMD_W-1:0] in_cmd;
    } t_ctl_sts;

endpackage

// File: hdl/ibrl_ctrl.sv
// ----------------------------------------------------------------------------
// ibrl_ctrl
// Sequencer of the lookup unit: clearing pass, command dispatch, per-level
// node walk and result hand-off to the output register.
// ----------------------------------------------------------------------------
module ibrl_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ibrl_pkg::t_ctl_cmd  o_cmd,
    input  ibrl_pkg::t_ctl_sts  i_sts
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_KDIV,
        ST_KWR,
        ST_EWR,
        ST_RD,
        ST_CMP,
        ST_TRD,
        ST_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   in_fire;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign in_fire     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_cmd.cap = i_in_valid;
                if (i_in_valid) begin
                    case (i_sts.in_cmd)
                        ibrl_pkg::CMD_KEY_WR: n_state = ST_KDIV;
                        ibrl_pkg::CMD_ENT_WR: n_state = ST_EWR;
                        ibrl_pkg::CMD_LOOKUP: n_state = i_sts.depth_zero ? ST_TRD : ST_RD;
                        default:              n_state = ST_DONE;
                    endcase
                end
            end
            ST_KDIV: begin
                o_cmd.kdiv = 1'b1;
                n_state    = ST_KWR;
            end
            ST_KWR: begin
                o_cmd.kwr = 1'b1;
                n_state   = ST_DONE;
            end
            ST_EWR: begin
                o_cmd.ewr = 1'b1;
                n_state   = ST_DONE;
            end
            ST_RD: begin
                o_cmd.node_rd = 1'b1;
                n_state       = ST_CMP;
            end
            ST_CMP: begin
                o_cmd.node_cmp = 1'b1;
                n_state        = i_sts.lvl_last ? ST_TRD : ST_RD;
            end
            ST_TRD: begin
                o_cmd.tgt_rd = 1'b1;
                n_state      = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register is free or drains now
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_fire_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state != ST_IDLE))
        else $error("accepted item did not start work");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_DONE))
        else $error("result shown without finishing an item");

endmodule

// File: hdl/ibrl_dpath.sv
// ----------------------------------------------------------------------------
// ibrl_dpath
// Datapath of the lookup unit: item capture, key store of node rows, target
// entry store, node search, step-down arithmetic and result register.
// ----------------------------------------------------------------------------
module ibrl_dpath #(
    parameter int NODE_KEYS      = 8,
    parameter int MAX_LEVELS     = 4,
    parameter int KEYS_PER_LEVEL = 1024,
    parameter int TARGET_SLOTS   = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  ibrl_pkg::t_ctl_cmd                   i_cmd,
    output ibrl_pkg::t_ctl_sts                   o_sts,
    input  logic [ibrl_pkg::IN_TDATA_W-1:0]      i_in_tdata,
    input  logic [ibrl_pkg::CMD_W-1:0]           i_in_tuser,
    input  logic                                 i_cfg_wr_en,
    input  logic [ibrl_pkg::DEPTH_W-1:0]         i_cfg_wr_data,
    output logic [ibrl_pkg::OUT_TDATA_W-1:0]     o_out_tdata,
    output logic                                 o_out_tuser
);

    localparam int K          = NODE_KEYS;
    localparam int KW         = ibrl_pkg::KEY_W;
    localparam int ROWS       = (KEYS_PER_LEVEL + K - 1) / K;
    localparam int LAST_LANES = KEYS_PER_LEVEL - (ROWS - 1) * K;
    localparam int KEY_ROWS   = MAX_LEVELS * ROWS;
    localparam int TSTORE     = (TARGET_SLOTS < 1024) ? TARGET_SLOTS : 1024;
    localparam int CAP_A      = (1024 + K - 1) / K;
    localparam int NODE_CAP   = (ROWS > CAP_A) ? ROWS : CAP_A;
    localparam int NODE_W     = $clog2(NODE_CAP + 1);
    localparam int NXT_W      = $clog2((K + 1) * NODE_CAP + K + 1);
    localparam int LEAF_W     = $clog2(K * NODE_CAP + K + 1);
    localparam int PICK_W     = $clog2(K + 1);
    localparam int LANE_W     = $clog2(K);
    localparam int LVL_W      = $clog2(MAX_LEVELS + 1);
    localparam int KRW        = (KEY_ROWS > 1) ? $clog2(KEY_ROWS) : 1;
    localparam int TW         = $clog2(TSTORE);
    localparam int CLR_LEN    = (KEY_ROWS > TSTORE) ? KEY_ROWS : TSTORE;
    localparam int CLR_W      = $clog2(CLR_LEN);
    localparam int SW         = ibrl_pkg::SLOT_W;
    localparam int DIV_S      = SW + LANE_W + 1;
    localparam int DIV_M      = ((1 << DIV_S) + K - 1) / K;
    localparam int ENT_W      = ibrl_pkg::TID_W + 1;

    // Captured item
    logic [ibrl_pkg::CMD_W-1:0]    r_cmd;
    logic [ibrl_pkg::LEVEL_W-1:0]  r_level;
    logic [SW-1:0]                 r_slot;
    logic [KW-1:0]                 r_key;
    logic                          r_pres;
    logic [ibrl_pkg::TID_W-1:0]    r_tid;
    logic [ibrl_pkg::SECTOR_W-1:0] r_sector;

    // Control and walk state
    logic [ibrl_pkg::DEPTH_W-1:0]  r_depth;
    logic [CLR_W-1:0]              r_clr_cnt;
    logic [NODE_W-1:0]             r_node;
    logic [PICK_W-1:0]             r_pick;
    logic [LVL_W-1:0]              r_lvl;
    logic [SW-1:0]                 r_q;

    // Stores
    logic [K*KW-1:0]  kmem [KEY_ROWS];
    logic [ENT_W-1:0] tmem [TSTORE];
    logic [K*KW-1:0]  r_krow;
    logic [ENT_W-1:0] r_tgt;

    // Result register
    logic [ibrl_pkg::OUT_TDATA_W-1:0] r_out_tdata;
    logic                             r_out_tuser;

    logic [LVL_W-1:0]  eff_depth;
    logic              lvl_last;
    logic [NODE_W-1:0] node_row;
    logic [31:0]       rd_row_full;
    logic [KRW-1:0]    rd_row;
    logic [K-1:0]      lane_ok;
    logic [K-1:0]      hit;
    logic [PICK_W-1:0] pick;
    logic [NXT_W-1:0]  node_nx;
    logic [NODE_W-1:0] node_nx_cl;
    logic [31:0]       div_prod;
    logic [31:0]       wr_row_full;
    logic [31:0]       wr_lane_full;
    logic [KRW-1:0]    wr_row;
    logic [LANE_W-1:0] wr_lane;
    logic              key_ok;
    logic              ent_ok;
    logic [LEAF_W-1:0] leaf;
    logic              leaf_in;
    logic [TW-1:0]     tgt_addr;
    logic              res_err;
    logic [ibrl_pkg::LEAF_SLOT_W-1:0] res_slot;
    logic [ibrl_pkg::TID_W-1:0]       res_tid;
    logic              is_lookup;

    // Depth above the level count walks all levels
    assign eff_depth = (32'(r_depth) > MAX_LEVELS) ? LVL_W'(MAX_LEVELS) : LVL_W'(r_depth);
    assign lvl_last  = ((32'(r_lvl) + 32'd1) == 32'(eff_depth));

    assign o_sts.clr_last   = (32'(r_clr_cnt) == (CLR_LEN - 1));
    assign o_sts.depth_zero = (eff_depth == '0);
    assign o_sts.lvl_last   = lvl_last;
    assign o_sts.in_cmd     = i_in_tuser;

    // Node row address; nodes past the level end read nothing useful
    assign node_row    = (32'(r_node) < ROWS) ? r_node : '0;
    assign rd_row_full = 32'(r_lvl) * 32'(ROWS) + 32'(node_row);
    assign rd_row      = rd_row_full[KRW-1:0];

    // Key positions past the level end read as all ones
    always_comb begin
        for (int k = 0; k < K; k++) begin
            if (32'(r_node) < (ROWS - 1)) begin
                lane_ok[k] = 1'b1;
            end else if (32'(r_node) == (ROWS - 1)) begin
                lane_ok[k] = (k < LAST_LANES);
            end else begin
                lane_ok[k] = 1'b0;
            end
            hit[k] = lane_ok[k] ? (r_krow[k*KW +: KW] >= r_sector) : 1'b1;
        end
    end

    // First key at or above the sector, K if none
    always_comb begin
        pick = PICK_W'(K);
        for (int k = K - 1; k >= 0; k--) begin
            if (hit[k]) begin
                pick = PICK_W'(k);
            end
        end
    end

    // Child node; a node past the cap only ever leads out of range
    assign node_nx    = NXT_W'(r_node) * NXT_W'(K + 1) + NXT_W'(pick);
    assign node_nx_cl = (node_nx > NXT_W'(NODE_CAP)) ? NODE_W'(NODE_CAP) : node_nx[NODE_W-1:0];

    // Key slot split by reciprocal multiply, exact for all slot values
    assign div_prod     = 32'(r_slot) * 32'(DIV_M);
    assign wr_row_full  = 32'(r_level) * 32'(ROWS) + 32'(r_q);
    assign wr_row       = wr_row_full[KRW-1:0];
    assign wr_lane_full = 32'(r_slot) - 32'(r_q) * 32'(K);
    assign wr_lane      = wr_lane_full[LANE_W-1:0];
    assign key_ok       = (32'(r_level) < MAX_LEVELS) && (32'(r_slot) < KEYS_PER_LEVEL);
    assign ent_ok       = (32'(r_slot) < TSTORE);

    // Leaf slot and target entry
    assign leaf     = LEAF_W'(r_node) * LEAF_W'(K) + LEAF_W'(r_pick);
    assign leaf_in  = (leaf < LEAF_W'(TSTORE));
    assign tgt_addr = leaf_in ? leaf[TW-1:0] : '0;

    assign is_lookup = (r_cmd == ibrl_pkg::CMD_LOOKUP);
    assign res_err   = !(leaf_in && r_tgt[ENT_W-1]);
    assign res_slot  = (leaf > LEAF_W'(ibrl_pkg::LEAF_SLOT_MAX)) ?
                       ibrl_pkg::LEAF_SLOT_MAX : leaf[ibrl_pkg::LEAF_SLOT_W-1:0];
    assign res_tid   = res_err ? '0 : r_tgt[ibrl_pkg::TID_W-1:0];

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth   <= '0;
            r_clr_cnt <= '0;
            r_node    <= '0;
            r_pick    <= '0;
            r_lvl     <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_depth <= i_cfg_wr_data;
            end
            if (i_cmd.clr) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (i_cmd.cap) begin
                r_node <= '0;
                r_pick <= '0;
                r_lvl  <= '0;
            end else if (i_cmd.node_cmp) begin
                r_pick <= pick;
                r_lvl  <= r_lvl + 1'b1;
                if (!lvl_last) begin
                    r_node <= node_nx_cl;
                end
            end
        end
    end

    // Item capture and key split
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_cmd    <= i_in_tuser;
            r_level  <= i_in_tdata[ibrl_pkg::LEVEL_LSB +: ibrl_pkg::LEVEL_W];
            r_slot   <= i_in_tdata[ibrl_pkg::SLOT_LSB +: SW];
            r_key    <= i_in_tdata[ibrl_pkg::KEY_LSB +: KW];
            r_pres   <= i_in_tdata[ibrl_pkg::PRES_LSB];
            r_tid    <= i_in_tdata[ibrl_pkg::TID_LSB +: ibrl_pkg::TID_W];
            r_sector <= i_in_tdata[ibrl_pkg::SECTOR_LSB +: ibrl_pkg::SECTOR_W];
        end
        if (i_cmd.kdiv) begin
            r_q <= div_prod[DIV_S +: SW];
        end
    end

    // Key store, one node per row
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            if (32'(r_clr_cnt) < KEY_ROWS) begin
                kmem[r_clr_cnt[KRW-1:0]] <= '0;
            end
        end else if (i_cmd.kwr && key_ok) begin
            for (int k = 0; k < K; k++) begin
                if (wr_lane == LANE_W'(k)) begin
                    kmem[wr_row][k*KW +: KW] <= r_key;
                end
            end
        end
        if (i_cmd.node_rd) begin
            r_krow <= kmem[rd_row];
        end
    end

    // Target entry store: present flag above the id
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            if (32'(r_clr_cnt) < TSTORE) begin
                tmem[r_clr_cnt[TW-1:0]] <= '0;
            end
        end else if (i_cmd.ewr && ent_ok) begin
            tmem[r_slot[TW-1:0]] <= {r_pres, r_tid};
        end
        if (i_cmd.tgt_rd) begin
            r_tgt <= tmem[tgt_addr];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_tdata <= '0;
            r_out_tuser <= is_lookup;
            if (is_lookup) begin
                r_out_tdata[ibrl_pkg::LEAF_LSB +: ibrl_pkg::LEAF_SLOT_W] <= res_slot;
                r_out_tdata[ibrl_pkg::FTID_LSB +: ibrl_pkg::TID_W]       <= res_tid;
                r_out_tdata[ibrl_pkg::IOERR_LSB]                         <= res_err;
            end
        end
    end

    assign o_out_tdata = r_out_tdata;
    assign o_out_tuser = r_out_tuser;

    a_walk_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.node_cmp |-> (32'(r_lvl) < 32'(eff_depth)))
        else $error("node search past the configured depth");

    a_node_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.node_rd |-> (32'(r_node) <= NODE_CAP))
        else $error("node index beyond its cap");

    a_split_before_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.kwr |-> $past(i_cmd.kdiv))
        else $error("key written without a fresh slot split");

endmodule

// File: hdl/implicit_btree_range_lookup_unit.sv
// Steps: a key write splits the slot into node row and lane, then writes the key; an
//   entry write writes the entry; an unknown command changes nothing; a lookup walks D
//   levels, D the tree depth clamped to MAX_LEVELS, then reads the leaf's target entry.
// Throughput: one item at a time, taken the cycle after the result loads; per level a
//   lookup does one key-store row read, then the node compare.
// Reset: synchronous, active low, then a clearing pass over the key and target stores.
// ----------------------------------------------------------------------------
// implicit_btree_range_lookup_unit
// Sector to target-slot lookup through a pointerless B-tree, with commands
// to load keys and target entries.
// ----------------------------------------------------------------------------
module implicit_btree_range_lookup_unit #(
    parameter int NODE_KEYS      = 8,
    parameter int MAX_LEVELS     = 4,
    parameter int KEYS_PER_LEVEL = 1024,
    parameter int TARGET_SLOTS   = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input items
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // level[1:0], slot[11:2], key_value[43:12], target_present[44],
    // target_id[60:45], sector[92:61], zero pad[95:93]
    input  logic [ibrl_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // command[1:0]
    input  logic [ibrl_pkg::CMD_W-1:0]         s_axis_tuser,
    // Result items
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // leaf_slot[9:0], found_target[25:10], no_target[26], zero pad[31:27]
    output logic [ibrl_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // is_lookup[0]
    output logic [0:0]                         m_axis_tuser,
    // Tree depth register
    input  logic                               i_cfg_wr_en,
    input  logic [ibrl_pkg::DEPTH_W-1:0]       i_cfg_wr_data
);

    ibrl_pkg::t_ctl_cmd ctl_cmd;
    ibrl_pkg::t_ctl_sts ctl_sts;
    logic               out_tuser;

    // Sequencer: clearing pass, dispatch, level walk, result hand-off
    ibrl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (ctl_cmd),
        .i_sts       (ctl_sts)
    );

    // Stores, node search and result register
    ibrl_dpath #(
        .NODE_KEYS      (NODE_KEYS),
        .MAX_LEVELS     (MAX_LEVELS),
        .KEYS_PER_LEVEL (KEYS_PER_LEVEL),
        .TARGET_SLOTS   (TARGET_SLOTS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (ctl_cmd),
        .o_sts         (ctl_sts),
        .i_in_tdata    (s_axis_tdata),
        .i_in_tuser    (s_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_out_tdata   (m_axis_tdata),
        .o_out_tuser   (out_tuser)
    );

    assign m_axis_tuser[0] = out_tuser;

endmodule

// File: verif/implicit_btree_range_lookup_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// implicit_btree_range_lookup_unit_checker
// Watches the item channels and the depth register of the lookup unit. It
// keeps its own copy of the key, present and target id stores, works out
// the answer of every accepted item and compares it with the result items.
// ----------------------------------------------------------------------------
module implicit_btree_range_lookup_unit_checker #(
    parameter int NODE_KEYS      = 8,
    parameter int MAX_LEVELS     = 4,
    parameter int KEYS_PER_LEVEL = 1024,
    parameter int TARGET_SLOTS   = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  logic [ibrl_pkg::IN_TDATA_W-1:0]  i_in_data,
    input  logic [ibrl_pkg::CMD_W-1:0]       i_in_user,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic [ibrl_pkg::OUT_TDATA_W-1:0] i_out_data,
    input  logic [0:0]                       i_out_user,
    input  logic                             i_cfg_wr_en,
    input  logic [ibrl_pkg::DEPTH_W-1:0]     i_cfg_wr_data,
    output int                               o_fail_count,
    output int                               o_pending
);
    import ibrl_pkg::*;

    typedef struct packed {
        logic [LEAF_SLOT_W-1:0] leaf_slot;
        logic [TID_W-1:0]       found_target;
        logic                   no_target;
        logic                   is_lookup;
    } t_answer;

    logic [KEY_W-1:0] key_mem [MAX_LEVELS*KEYS_PER_LEVEL];
    logic             present_mem [TARGET_SLOTS];
    logic [TID_W-1:0] tid_mem [TARGET_SLOTS];
    logic [DEPTH_W-1:0] depth_reg;

    t_answer answer_q [$];
    t_answer want;
    t_answer got;
    int      fail_total = 0;

    // Walk the levels from the root node and resolve the leaf entry.
    function automatic t_answer walk_tree(input logic [SECTOR_W-1:0] sector);
        int unsigned     depth;
        longint unsigned node;
        longint unsigned pick;
        longint unsigned base;
        longint unsigned leaf;
        logic [KEY_W-1:0] key;
        t_answer         ans;
        depth = (depth_reg > MAX_LEVELS) ? MAX_LEVELS : depth_reg;
        node = 0;
        pick = 0;
        for (int lvl = 0; lvl < depth; lvl++) begin
            node = (NODE_KEYS + 1) * node + pick;
            base = node * NODE_KEYS;
            pick = NODE_KEYS;
            for (int k = 0; k < NODE_KEYS; k++) begin
                // past the end of a level every key reads as all ones
                if (base + k >= KEYS_PER_LEVEL)
                    key = '1;
                else
                    key = key_mem[lvl*KEYS_PER_LEVEL + base + k];
                if (pick == NODE_KEYS && key >= sector)
                    pick = k;
            end
        end
        leaf = NODE_KEYS * node + pick;
        ans.is_lookup = 1'b1;
        ans.leaf_slot = (leaf > LEAF_SLOT_MAX) ? LEAF_SLOT_MAX : leaf[LEAF_SLOT_W-1:0];
        ans.no_target = !(leaf < TARGET_SLOTS && present_mem[leaf]);
        ans.found_target = ans.no_target ? '0 : tid_mem[leaf];
        return ans;
    endfunction

    // Apply one input item to the stores and return its answer.
    function automatic t_answer apply_command(input logic [CMD_W-1:0] cmd,
                                              input logic [IN_TDATA_W-1:0] word);
        logic [LEVEL_W-1:0]  lvl;
        logic [SLOT_W-1:0]   slot;
        t_answer             ans;
        lvl  = word[LEVEL_LSB +: LEVEL_W];
        slot = word[SLOT_LSB +: SLOT_W];
        ans  = '0;
        case (cmd)
            CMD_KEY_WR: begin
                if (lvl < MAX_LEVELS && slot < KEYS_PER_LEVEL)
                    key_mem[lvl*KEYS_PER_LEVEL + slot] = word[KEY_LSB +: KEY_W];
            end
            CMD_ENT_WR: begin
                if (slot < TARGET_SLOTS) begin
                    present_mem[slot] = word[PRES_LSB];
                    tid_mem[slot]     = word[TID_LSB +: TID_W];
                end
            end
            CMD_LOOKUP: begin
                ans = walk_tree(word[SECTOR_LSB +: SECTOR_W]);
            end
            default: begin
                // unknown command: plain acknowledge, nothing changes
            end
        endcase
        return ans;
    endfunction

    task automatic note_mismatch(input string field, input longint unsigned exp_val,
                                 input longint unsigned act_val);
        fail_total++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                 $time, field, exp_val, act_val);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_LEVELS*KEYS_PER_LEVEL; i++)
                key_mem[i] = '0;
            for (int i = 0; i < TARGET_SLOTS; i++) begin
                present_mem[i] = 1'b0;
                tid_mem[i]     = '0;
            end
            depth_reg = '0;
            answer_q.delete();
        end else begin
            if (i_cfg_wr_en)
                depth_reg = i_cfg_wr_data;
            if (i_in_valid && i_in_ready)
                answer_q.push_back(apply_command(i_in_user, i_in_data));
            if (i_out_valid && i_out_ready) begin
                got.leaf_slot    = i_out_data[LEAF_LSB +: LEAF_SLOT_W];
                got.found_target = i_out_data[FTID_LSB +: TID_W];
                got.no_target    = i_out_data[IOERR_LSB];
                got.is_lookup    = i_out_user[0];
                if (answer_q.size() == 0) begin
                    fail_total++;
                    $display("%0t: unexpected result, expected none, actual 0x%0h",
                             $time, got);
                end else begin
                    want = answer_q.pop_front();
                    if (got.leaf_slot != want.leaf_slot)
                        note_mismatch("leaf_slot", want.leaf_slot, got.leaf_slot);
                    if (got.found_target != want.found_target)
                        note_mismatch("found_target", want.found_target, got.found_target);
                    if (got.no_target != want.no_target)
                        note_mismatch("no_target", want.no_target, got.no_target);
                    if (got.is_lookup != want.is_lookup)
                        note_mismatch("is_lookup", want.is_lookup, got.is_lookup);
                end
            end
        end
        o_pending    <= answer_q.size();
        o_fail_count <= fail_total;
    end

endmodule

// File: verif/implicit_btree_range_lookup_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// implicit_btree_range_lookup_unit_tb
// Drives key writes, target entry writes, lookups and unknown commands into
// the lookup unit over a range of tree depths, with random idle cycles on
// both item channels. The checker beside the block predicts every answer.
// ----------------------------------------------------------------------------
module implicit_btree_range_lookup_unit_tb;
    import ibrl_pkg::*;

    localparam int NODE_KEYS      = 8;
    localparam int MAX_LEVELS     = 4;
    localparam int KEYS_PER_LEVEL = 1024;
    localparam int TARGET_SLOTS   = 1024;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 1500;
    localparam int PHASE_ITEMS  = 100;   // items between two depth changes
    localparam int IDLE_PCT     = 12;    // idle cycles per hundred, each side
    localparam int BURST_PHASE  = 5;     // phase run with no idling at all
    localparam int TAIL_CYCLES  = 40;    // well past the longest lookup
    localparam int LIMIT_CYCLES = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                   s_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [CMD_W-1:0]       s_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   sink_ready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [0:0]             m_axis_tuser;
    logic                   cfg_wr_en = 1'b0;
    logic [DEPTH_W-1:0]     cfg_wr_data = '0;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int items_sent = 0;
    logic burst_phase = 1'b0;

    // Recently written keys; lookups aim at them so the compares split.
    logic [KEY_W-1:0] key_pool [16];
    int               pool_wr = 0;

    always #5 clk = ~clk;

    implicit_btree_range_lookup_unit #(
        .NODE_KEYS     (NODE_KEYS),
        .MAX_LEVELS    (MAX_LEVELS),
        .KEYS_PER_LEVEL(KEYS_PER_LEVEL),
        .TARGET_SLOTS  (TARGET_SLOTS)
    ) dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (sink_ready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    implicit_btree_range_lookup_unit_checker #(
        .NODE_KEYS     (NODE_KEYS),
        .MAX_LEVELS    (MAX_LEVELS),
        .KEYS_PER_LEVEL(KEYS_PER_LEVEL),
        .TARGET_SLOTS  (TARGET_SLOTS)
    ) checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (s_tvalid),
        .i_in_ready    (s_axis_tready),
        .i_in_data     (s_tdata),
        .i_in_user     (s_tuser),
        .i_out_valid   (m_axis_tvalid),
        .i_out_ready   (sink_ready),
        .i_out_data    (m_axis_tdata),
        .i_out_user    (m_axis_tuser),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // Stall the result channel at random, except in the burst phase.
    always @(posedge clk) begin
        sink_ready <= burst_phase ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Watchdog: end the run if the block hangs.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Offer one item and hold it until the block takes it. Idle cycles go in
    // front of the item; valid stays high into the next item otherwise.
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [LEVEL_W-1:0] lvl,
                             input logic [SLOT_W-1:0] slot, input logic [KEY_W-1:0] key,
                             input logic pres, input logic [TID_W-1:0] tid,
                             input logic [SECTOR_W-1:0] sector);
        logic [IN_TDATA_W-1:0] word;
        while (!burst_phase && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        word = '0;
        word[LEVEL_LSB +: LEVEL_W]   = lvl;
        word[SLOT_LSB +: SLOT_W]     = slot;
        word[KEY_LSB +: KEY_W]       = key;
        word[PRES_LSB]               = pres;
        word[TID_LSB +: TID_W]       = tid;
        word[SECTOR_LSB +: SECTOR_W] = sector;
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= cmd;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
    endtask

    // Drain all outstanding answers, then write the tree depth.
    task automatic set_depth(input logic [DEPTH_W-1:0] depth);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= depth;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Fill one reachable node of a random level with sorted keys.
    task automatic load_random_node();
        int unsigned      lvl;
        int unsigned      top_node;
        int unsigned      node;
        int unsigned      j;
        logic [KEY_W-1:0] keys [NODE_KEYS];
        logic [KEY_W-1:0] t;
        logic             narrow;
        lvl = $urandom_range(0, MAX_LEVELS - 1);
        // nodes reachable from the root at this level, capped by the level size
        top_node = 1;
        repeat (lvl) top_node = top_node * (NODE_KEYS + 1);
        top_node = top_node - 1;
        if (top_node > KEYS_PER_LEVEL / NODE_KEYS - 1)
            top_node = KEYS_PER_LEVEL / NODE_KEYS - 1;
        node = $urandom_range(0, top_node);
        narrow = ($urandom_range(0, 99) < 30);
        for (int k = 0; k < NODE_KEYS; k++)
            keys[k] = narrow ? KEY_W'($urandom_range(0, 1000)) : KEY_W'($urandom);
        for (int k = 1; k < NODE_KEYS; k++) begin
            t = keys[k];
            j = k;
            while (j > 0 && keys[j-1] > t) begin
                keys[j] = keys[j-1];
                j--;
            end
            keys[j] = t;
        end
        for (int k = 0; k < NODE_KEYS; k++) begin
            send_item(CMD_KEY_WR, LEVEL_W'(lvl), SLOT_W'(node*NODE_KEYS + k), keys[k],
                      1'b0, '0, '0);
            key_pool[pool_wr] = keys[k];
            pool_wr = (pool_wr + 1) % 16;
        end
    endtask

    // One random step: mostly tree building, entries and lookups, some noise.
    // Fields a command does not use carry random bits.
    task automatic random_step();
        int               r;
        int               pick;
        logic [LEVEL_W-1:0]  lvl;
        logic [SLOT_W-1:0]   slot;
        logic [KEY_W-1:0]    key;
        logic                pres;
        logic [TID_W-1:0]    tid;
        logic [SECTOR_W-1:0] sector;
        lvl    = LEVEL_W'($urandom);
        slot   = SLOT_W'($urandom);
        key    = $urandom;
        pres   = 1'($urandom);
        tid    = TID_W'($urandom);
        sector = $urandom;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            load_random_node();
        end else if (r < 40) begin
            // favor the leaves that shallow trees can reach
            pick = $urandom_range(0, 99);
            if (pick < 40)
                slot = SLOT_W'($urandom_range(0, 80));
            else if (pick < 70)
                slot = SLOT_W'($urandom_range(0, 720));
            pres = ($urandom_range(0, 99) < 85);
            send_item(CMD_ENT_WR, lvl, slot, key, pres, tid, sector);
        end else if (r < 90) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                sector = key_pool[$urandom_range(0, 15)];
            else if (pick < 60)
                sector = key_pool[$urandom_range(0, 15)] + 1'b1;
            else if (pick < 75)
                sector = $urandom_range(0, 1000);
            send_item(CMD_LOOKUP, lvl, slot, key, pres, tid, sector);
        end else if (r < 96) begin
            send_item(CMD_KEY_WR, lvl, slot, key, pres, tid, sector);
        end else begin
            send_item(CMD_UNUSED, lvl, slot, key, pres, tid, sector);
        end
    endtask

    initial begin
        int phase;
        int batch_end;
        for (int i = 0; i < 16; i++)
            key_pool[i] = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, tree depth still at its reset value of zero.
        // Lookup into freshly cleared stores: leaf 0 with no target.
        send_item(CMD_LOOKUP, 0, 0, 0, 1'b0, 0, 32'h0000_0000);
        send_item(CMD_ENT_WR, 0, 0, 0, 1'b1, 16'hFFFF, 0);
        send_item(CMD_LOOKUP, 0, 0, 0, 1'b0, 0, 32'hFFFF_FFFF);
        send_item(CMD_ENT_WR, 0, 1023, 0, 1'b1, 16'h0000, 0);
        // absent entry that still carries an id
        send_item(CMD_ENT_WR, 0, 8, 0, 1'b0, 16'h1234, 0);
        send_item(CMD_KEY_WR, 0, 0, 32'h0000_0000, 1'b0, 0, 0);
        send_item(CMD_KEY_WR, 0, 1, 32'd100, 1'b0, 0, 0);
        send_item(CMD_KEY_WR, 3, 1023, 32'hFFFF_FFFF, 1'b0, 0, 0);
        // unknown command with every field at all ones
        send_item(CMD_UNUSED, '1, '1, '1, 1'b1, '1, '1);

        // One level: hit on the first key, on the second, and fall past all.
        set_depth(1);
        send_item(CMD_LOOKUP, 0, 0, 0, 1'b0, 0, 32'd0);
        send_item(CMD_LOOKUP, 0, 0, 0, 1'b0, 0, 32'd50);
        send_item(CMD_LOOKUP, 0, 0, 0, 1'b0, 0, 32'd100);
        send_item(CMD_LOOKUP, 0, 0, 0, 1'b0, 0, 32'hFFFF_FFFF);

        // Depth above the level count: walk is clamped; leaf past the
        // target table saturates with an error.
        set_depth(7);
        send_item(CMD_LOOKUP, 0, 0, 0, 1'b0, 0, 32'd1);
        send_item(CMD_LOOKUP, 0, 0, 0, 1'b0, 0, 32'd0);

        // Full depth: steer sector 50 down to the last leaf, 1023, which
        // also reads the last key of the deepest level.
        set_depth(4);
        send_item(CMD_LOOKUP, 0, 0, 0, 1'b0, 0, 32'hFFFF_FFFF);
        send_item(CMD_KEY_WR, 1, 13, 32'd60, 1'b0, 0, 0);
        send_item(CMD_KEY_WR, 2, 113, 32'd60, 1'b0, 0, 0);
        send_item(CMD_LOOKUP, 0, 0, 0, 1'b0, 0, 32'd50);
        send_item(CMD_ENT_WR, 0, 1023, 0, 1'b0, 16'hA5A5, 0);
        send_item(CMD_LOOKUP, 0, 0, 0, 1'b0, 0, 32'd50);

        // Random part: step through every depth first, then pick at random.
        phase = 0;
        batch_end = items_sent + RANDOM_ITEMS;
        while (items_sent < batch_end) begin
            set_depth(DEPTH_W'(phase < 8 ? phase : $urandom_range(0, 7)));
            burst_phase <= (phase == BURST_PHASE);
            begin
                int phase_end;
                phase_end = items_sent + PHASE_ITEMS;
                while (items_sent < phase_end)
                    random_step();
            end
            phase++;
        end
        burst_phase <= 1'b0;

        // Drop valid, drain the answers and give the block time to misbehave.
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
